FILE: hw/rtl/point_in_polygon_test_core_defines.svh
// Assertion macros for the point-in-polygon core
`ifndef POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PIPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PIPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIPT_ASSERT(lbl, prop, msg)
`define PIPT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/pipt_pkg.sv
// Shared types and constants for the point-in-polygon core
`timescale 1ns / 1ps
package pipt_pkg;

  localparam int PIPT_MAX_VERTICES = 64;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 7;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  typedef struct packed {
    logic               inside_res;
    logic               table_overflow;
    logic [COUNT_W-1:0] stored_count;
  } rsp_t;

endpackage

FILE: hw/rtl/pipt_if.sv
// Request and response channel interfaces
`timescale 1ns / 1ps
interface pipt_req_if import pipt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               restart;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;

  modport source (output valid, req_type, restart, coord_x, coord_y, input ready);
  modport sink   (input valid, req_type, restart, coord_x, coord_y, output ready);
endinterface

interface pipt_rsp_if import pipt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic               table_overflow;
  logic [COUNT_W-1:0] stored_count;

  modport source (output valid, inside_res, table_overflow, stored_count, input ready);
  modport sink   (input valid, inside_res, table_overflow, stored_count, output ready);
endinterface

FILE: hw/rtl/pipt_vmem.sv
// Vertex memory: one write port, one registered read port
`timescale 1ns / 1ps
module pipt_vmem import pipt_pkg::*; #(
  parameter int DEPTH = PIPT_MAX_VERTICES,
  parameter int AW    = $clog2(PIPT_MAX_VERTICES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  vertex_t       wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output vertex_t       rd_data
);

  vertex_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/pipt_edge.sv
// Edge crossing pipeline: straddle test, cross products, parity
`timescale 1ns / 1ps
module pipt_edge import pipt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] qx,
  input  logic [COORD_W-1:0] qy,
  input  tag_t               tag,
  input  vertex_t            vtx,
  output logic               done,
  output logic               odd
);

  localparam int SDW = COORD_W + 1;
  localparam int PW  = 2 * SDW;

  logic [COORD_W-1:0] qx_r, qy_r, px, py;
  logic               straddle, prefilter;
  logic signed [SDW-1:0] a, b, c, d;

  logic                  s1_valid, s1_last, s1_cnt, s1_pos;
  logic signed [SDW-1:0] s1_a, s1_b, s1_c, s1_d;
  logic                  s2_valid, s2_last, s2_cnt, s2_pos;
  logic signed [PW-1:0]  s2_l, s2_r;
  logic                  left;

  always_comb begin
    straddle  = (vtx.y < qy_r && py >= qy_r) || (py < qy_r && vtx.y >= qy_r);
    prefilter = (vtx.x <= qx_r) || (px <= qx_r);
    a = $signed({1'b0, qy_r}) - $signed({1'b0, vtx.y});
    b = $signed({1'b0, px}) - $signed({1'b0, vtx.x});
    c = $signed({1'b0, qx_r}) - $signed({1'b0, vtx.x});
    d = $signed({1'b0, py}) - $signed({1'b0, vtx.y});
    left = s2_pos ? (s2_l < s2_r) : (s2_l > s2_r);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qx_r <= qx;
      qy_r <= qy;
    end
    if (tag.valid) begin
      px <= vtx.x;
      py <= vtx.y;
    end
    s1_cnt <= straddle && prefilter;
    s1_pos <= (py > vtx.y);
    s1_a   <= a;
    s1_b   <= b;
    s1_c   <= c;
    s1_d   <= d;
    s2_l   <= s1_a * s1_b;
    s2_r   <= s1_c * s1_d;
    s2_cnt <= s1_cnt;
    s2_pos <= s1_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
      done     <= 1'b0;
      odd      <= 1'b0;
    end else begin
      s1_valid <= tag.valid && !tag.first;
      s1_last  <= tag.last;
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
      done     <= s2_valid && s2_last;
      if (start) begin
        odd <= 1'b0;
      end else if (s2_valid && s2_cnt && left) begin
        odd <= !odd;
      end
    end
  end

endmodule

FILE: hw/rtl/point_in_polygon_test_core.sv
// Point-in-polygon core: vertex table, sweep control, result register
//
// Requests arrive on req (valid/ready). An append beat (req_type 0) stores
// one vertex; restart empties the table first. A plain append to a full
// table is dropped and answers with table_overflow set. A query beat
// (req_type 1) tests the point by the even-odd crossing rule over all
// stored edges and answers with inside_res.
// Every request yields exactly one beat on rsp, carrying stored_count.
// An append or a query on an empty table answers through the output
// register, or through the holding slot while rsp is stalled. A query
// with N stored vertices reads the vertex memory once per cycle through its
// single read port (N + 1 reads, the last vertex first), then answers
// when the edge pipeline is done; req is held off until then.
// The result sits in an output register with a one-beat holding slot
// behind it: a new request is accepted while a result waits on rsp, and
// outside a query req stalls only once both are full.
// Reset empties the table (vertex count zero) and drops any pending beat.
`timescale 1ns / 1ps
`include "point_in_polygon_test_core_defines.svh"
module point_in_polygon_test_core import pipt_pkg::*; #(
  parameter int MAX_VERTICES = PIPT_MAX_VERTICES
) (
  input  logic         clk,
  input  logic         rst,
  pipt_req_if.sink     req,
  pipt_rsp_if.source   rsp
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);

  state_t         state;
  logic [CW-1:0]  cnt, cnt_next;
  logic [AW-1:0]  idx, last_idx;
  tag_t           rd_tag, dat_tag;
  logic           accept, full, is_query;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  vertex_t        wr_data, rd_data;
  logic           e_done, e_odd;
  logic           fin_valid, pend_valid, out_free, out_load;
  rsp_t           fin, pend, out_src;

  assign req.ready = (state == ST_IDLE) && !pend_valid;
  assign accept    = req.valid && req.ready;
  assign is_query  = (req.req_type == REQ_QUERY);
  assign full      = (cnt == CNT_MAX);
  assign wr_data   = '{x: req.coord_x, y: req.coord_y};
  assign wr_addr   = req.restart ? '0 : cnt[AW-1:0];

  always_comb begin
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx;
    rd_tag    = '0;
    cnt_next  = cnt;
    fin_valid = 1'b0;
    fin       = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!is_query) begin
            if (req.restart || !full) begin
              wr_en    = 1'b1;
              cnt_next = req.restart ? CW'(1) : cnt + CW'(1);
            end else begin
              fin.table_overflow = 1'b1;
            end
            fin_valid        = 1'b1;
            fin.stored_count = COUNT_W'(cnt_next);
          end else if (cnt == '0) begin
            fin_valid        = 1'b1;
            fin.stored_count = COUNT_W'(cnt);
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(cnt - CW'(1));
            rd_tag  = '{valid: 1'b1, first: 1'b1, last: 1'b0};
          end
        end
      end
      ST_SWEEP: begin
        rd_en   = 1'b1;
        rd_addr = idx;
        rd_tag  = '{valid: 1'b1, first: 1'b0, last: (idx == last_idx)};
      end
      ST_WAIT: begin
        if (e_done) begin
          fin_valid        = 1'b1;
          fin.inside_res   = e_odd;
          fin.stored_count = COUNT_W'(cnt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      dat_tag <= '0;
    end else begin
      cnt     <= cnt_next;
      dat_tag <= rd_tag;
      case (state)
        ST_IDLE: begin
          if (accept && is_query && cnt != '0) begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (idx == last_idx) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (e_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      idx      <= '0;
      last_idx <= AW'(cnt - CW'(1));
    end else begin
      idx <= idx + AW'(1);
    end
  end

  // output register plus one holding slot
  assign out_free = !rsp.valid || rsp.ready;
  assign out_load = (fin_valid || pend_valid) && out_free;
  assign out_src  = pend_valid ? pend : fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (fin_valid && !out_free) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && !out_free) begin
      pend <= fin;
    end
    if (out_load) begin
      rsp.inside_res     <= out_src.inside_res;
      rsp.table_overflow <= out_src.table_overflow;
      rsp.stored_count   <= out_src.stored_count;
    end
  end

  pipt_vmem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_vmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pipt_edge u_edge (
    .clk   (clk),
    .rst   (rst),
    .start (accept && is_query),
    .qx    (req.coord_x),
    .qy    (req.coord_y),
    .tag   (dat_tag),
    .vtx   (rd_data),
    .done  (e_done),
    .odd   (e_odd)
  );

  `PIPT_ASSERT(a_no_write_busy, (state != ST_IDLE) |-> !wr_en, "table written during a sweep")
  `PIPT_ASSERT(a_cnt_range, cnt <= CNT_MAX, "vertex count beyond capacity")
  `PIPT_ASSERT(a_pend_out, pend_valid |-> rsp.valid, "held beat without output beat")
  `PIPT_ASSERT(a_done_wait, e_done |-> (state == ST_WAIT), "edge pipeline done outside a query")
  `PIPT_ASSERT_RST(a_rst, rst |=> (state == ST_IDLE && !rsp.valid && cnt == '0),
    "reset did not clear control")

endmodule
